[hdl/psgmrf_pkg.sv]
// psgmrf_pkg: shared types, constants and the sample formatting function
// of the sound mixer, resampler and formatter block
// no dependencies
`default_nettype none

package psgmrf_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_STEP    = 3'd0;
	localparam logic [2:0] CFG_MODE    = 3'd1;
	localparam logic [2:0] CFG_SPEAKER = 3'd2;
	localparam logic [2:0] CFG_DAC_EN  = 3'd3;
	localparam logic [2:0] CFG_STEREO  = 3'd4;
	localparam logic [2:0] CFG_WIDE    = 3'd5;
	localparam logic [2:0] CFG_SIGNED  = 3'd6;
	localparam logic [2:0] CFG_BIG_END = 3'd7;

	// output modes
	localparam logic [1:0] MODE_MONO    = 2'd0;
	localparam logic [1:0] MODE_SPEAKER = 2'd1;
	localparam logic [1:0] MODE_STEREO  = 2'd2;
	localparam logic [1:0] MODE_SILENT  = 2'd3;

	// shared multiplier geometry
	localparam int unsigned MUL_W  = 25;
	localparam int unsigned PROD_W = 2 * MUL_W;

	// reciprocals: x/11 = (x*MID_RECIP)>>23 for x < 2^19
	localparam logic [MUL_W-1:0] MID_RECIP = 25'd762601;
	// x/3 = (x*AVG_RECIP)>>19 for x < 2^19
	localparam logic [MUL_W-1:0] AVG_RECIP = 25'd174763;
	// x/255 = (x*SPK_RECIP)>>32 for x < 2^24
	localparam int unsigned SPEAKER_LEVEL_MAX = 255;
	localparam logic [MUL_W-1:0] SPK_RECIP = 25'd16843010;

	localparam logic [16:0] PHASE_ONE = 17'h10000;

	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  count;
	} fmt_t;

	function automatic logic [15:0] put16(input logic [15:0] v, input logic be);
		put16 = be ? {v[7:0], v[15:8]} : v;
	endfunction

	function automatic fmt_t format_sample(
		input logic [15:0] l,
		input logic [15:0] r,
		input logic        stereo,
		input logic        wide,
		input logic        sgn,
		input logic        be
	);
		fmt_t        f;
		logic [16:0] sum;
		logic [15:0] m;
		logic [15:0] lf;
		logic [15:0] rf;
		logic [15:0] mf;
		sum = {1'b0, l} + {1'b0, r};
		m   = sum[16:1];
		lf  = {l[15] ^ sgn, l[14:0]};
		rf  = {r[15] ^ sgn, r[14:0]};
		mf  = {m[15] ^ sgn, m[14:0]};
		if (stereo) begin
			if (!wide) begin
				f.bytes = {16'h0000, rf[15:8], lf[15:8]};
				f.count = 3'd2;
			end else begin
				f.bytes = {put16(rf, be), put16(lf, be)};
				f.count = 3'd4;
			end
		end else begin
			if (!wide) begin
				f.bytes = {24'h000000, mf[15:8]};
				f.count = 3'd1;
			end else begin
				f.bytes = {16'h0000, put16(mf, be)};
				f.count = 3'd2;
			end
		end
		return f;
	endfunction

endpackage

`default_nettype wire

[hdl/psgmrf_ifs.sv]
// psgmrf channel interfaces: input item, result item and configuration write
// depends on nothing
`default_nettype none

interface psgmrf_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] level_a;
	logic [15:0] level_b;
	logic [15:0] level_c;
	logic [7:0]  dac_level;
	logic [9:0]  cycle_count;
	modport source (output valid, level_a, level_b, level_c, dac_level, cycle_count,
		input ready);
	modport sink (input valid, level_a, level_b, level_c, dac_level, cycle_count,
		output ready);
endinterface

interface psgmrf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] frame_bytes;
	logic [2:0]  byte_count;
	logic        last;
	logic        dropped;
	modport source (output valid, frame_bytes, byte_count, last, dropped, input ready);
	modport sink (input valid, frame_bytes, byte_count, last, dropped, output ready);
endinterface

interface psgmrf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/psg_mix_resample_format_top.sv]
// psg_mix_resample_format_top: mixer, box-filter resampler and formatter
// depends on psgmrf_pkg, psgmrf_ifs and psgmrf_mul
//
// Usage:
//   cfg        register writes (index, data), always ready; write only while idle
//   sample_in  one item of three tone levels, a DAC byte and a cycle count
//   sample_out one transaction per completed output sample, last marks the
//              final one of an item, dropped marks items over the sample limit
// Sequencing:
//   all products go through one shared 25x25 multiplier under a sequencer
//   an item with no completed sample runs FS, MIX, MIXW, ACCL, ACCR and ACCW
//   before ready returns, with SPK1 and SPK2 after MIXW in speaker mode; an
//   item that completes samples then registers them in EMIT, waiting there
//   while the receiver stalls, and runs POSTL, POSTR and POSTW before ready
// Reset:
//   clears phase and partial sums and loads the register defaults
// Stall:
//   sample_out holds its transaction until taken; the sequencer waits, and
//   the next item is taken while the final result still waits
`default_nettype none

module psg_mix_resample_format_top #(
	parameter int unsigned MAX_SAMPLES_PER_ITEM = 64
) (
	input wire logic     clk,
	input wire logic     arst_n,
	psgmrf_in_if.sink    sample_in,
	psgmrf_out_if.source sample_out,
	psgmrf_cfg_if.sink   cfg
);

	localparam int unsigned CntW     = $clog2(MAX_SAMPLES_PER_ITEM + 1);
	localparam logic [10:0] MaxTotal = 11'(MAX_SAMPLES_PER_ITEM);

	typedef enum logic [3:0] {
		ST_IDLE, ST_FS, ST_MIX, ST_MIXW, ST_SPK1, ST_SPK2, ST_ACCL, ST_ACCR,
		ST_ACCW, ST_EMIT, ST_POSTL, ST_POSTR, ST_POSTW
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] step_q;
	logic [1:0]  mode_q;
	logic [7:0]  spk_q;
	logic        dac_en_q;
	logic        stereo_q;
	logic        wide_q;
	logic        sgn_q;
	logic        be_q;

	// item and datapath registers
	logic [15:0] a_q, b_q, c_q;
	logic [7:0]  dac_q;
	logic [9:0]  cyc_q;
	logic [25:0] fs_q;
	logic [16:0] w_q;
	logic        short_q;
	logic [15:0] lv_q, rv_q;
	logic [15:0] acc_l_q, acc_r_q, phase_q;
	logic [CntW-1:0] n_q, k_q;
	logic        drop_q;

	// output register
	logic        out_valid_q;
	logic [31:0] frame_q;
	logic [2:0]  count_q;
	logic        last_q;
	logic        dropped_q;

	// shared multiplier
	logic [psgmrf_pkg::MUL_W-1:0]  mul_x, mul_y;
	logic [psgmrf_pkg::PROD_W-1:0] prod;

	psgmrf_mul u_mul (
		.clk  (clk),
		.x    (mul_x),
		.y    (mul_y),
		.prod (prod)
	);

	// combinational helpers
	logic [18:0] b5;
	logic [17:0] sum3;
	logic [14:0] mid;
	logic [16:0] l_sum, r_sum;
	logic [15:0] l_sat, r_sat;
	logic [15:0] avg;
	logic [15:0] spk_v;
	logic [16:0] rem;
	logic        fs_short;
	logic [16:0] w_now;
	logic [25:0] t_val;
	logic [10:0] total;
	logic        out_free;
	logic        is_last;
	logic [15:0] l_sel, r_sel;
	psgmrf_pkg::fmt_t fmt;

	function automatic logic [15:0] dac_mix(input logic [15:0] x, input logic en,
		input logic [7:0] d);
		dac_mix = en ? ({1'b0, x[15:1]} + {1'b0, d, d[7:1]}) : x;
	endfunction

	assign b5       = {1'b0, b_q, 2'b00} + {3'b000, b_q};
	assign sum3     = {2'b00, a_q} + {2'b00, b_q} + {2'b00, c_q};
	assign mid      = prod[37:23];
	assign l_sum    = {1'b0, a_q} + {2'b00, mid};
	assign r_sum    = {1'b0, c_q} + {2'b00, mid};
	assign l_sat    = l_sum[16] ? 16'hFFFF : l_sum[15:0];
	assign r_sat    = r_sum[16] ? 16'hFFFF : r_sum[15:0];
	assign avg      = prod[34:19];
	assign spk_v    = prod[47:32];
	assign rem      = psgmrf_pkg::PHASE_ONE - {1'b0, phase_q};
	assign fs_short = fs_q < {9'd0, rem};
	assign w_now    = fs_short ? fs_q[16:0] : rem;
	assign t_val    = fs_q - {9'd0, w_q};
	assign total    = 11'd1 + {1'b0, t_val[25:16]};
	assign out_free = !out_valid_q || sample_out.ready;
	assign is_last  = (k_q + CntW'(1)) == n_q;
	assign l_sel    = (k_q == '0) ? acc_l_q : lv_q;
	assign r_sel    = (k_q == '0) ? acc_r_q : rv_q;
	assign fmt      = psgmrf_pkg::format_sample(l_sel, r_sel, stereo_q, wide_q, sgn_q, be_q);

	// multiplier operand selection
	always_comb begin
		mul_x = '0;
		mul_y = '0;
		unique case (state_q)
			ST_FS: begin
				mul_x = psgmrf_pkg::MUL_W'(step_q);
				mul_y = psgmrf_pkg::MUL_W'(cyc_q);
			end
			ST_MIX: begin
				if (mode_q == psgmrf_pkg::MODE_STEREO) begin
					mul_x = psgmrf_pkg::MUL_W'(b5);
					mul_y = psgmrf_pkg::MID_RECIP;
				end else begin
					mul_x = psgmrf_pkg::MUL_W'(sum3);
					mul_y = psgmrf_pkg::AVG_RECIP;
				end
			end
			ST_MIXW: begin
				mul_x = psgmrf_pkg::MUL_W'(avg);
				mul_y = psgmrf_pkg::MUL_W'(spk_q);
			end
			ST_SPK1: begin
				mul_x = psgmrf_pkg::MUL_W'(prod[23:0]);
				mul_y = psgmrf_pkg::SPK_RECIP;
			end
			ST_ACCL: begin
				mul_x = psgmrf_pkg::MUL_W'(lv_q);
				mul_y = psgmrf_pkg::MUL_W'(w_now);
			end
			ST_ACCR: begin
				mul_x = psgmrf_pkg::MUL_W'(rv_q);
				mul_y = psgmrf_pkg::MUL_W'(w_q);
			end
			ST_POSTL: begin
				mul_x = psgmrf_pkg::MUL_W'(lv_q);
				mul_y = psgmrf_pkg::MUL_W'(phase_q);
			end
			ST_POSTR: begin
				mul_x = psgmrf_pkg::MUL_W'(rv_q);
				mul_y = psgmrf_pkg::MUL_W'(phase_q);
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			mode_q   <= psgmrf_pkg::MODE_MONO;
			spk_q    <= 8'hFF;
			dac_en_q <= 1'b0;
			stereo_q <= 1'b1;
			wide_q   <= 1'b1;
			sgn_q    <= 1'b0;
			be_q     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				psgmrf_pkg::CFG_STEP:    step_q   <= cfg.data;
				psgmrf_pkg::CFG_MODE:    mode_q   <= cfg.data[1:0];
				psgmrf_pkg::CFG_SPEAKER: spk_q    <= cfg.data[7:0];
				psgmrf_pkg::CFG_DAC_EN:  dac_en_q <= cfg.data[0];
				psgmrf_pkg::CFG_STEREO:  stereo_q <= cfg.data[0];
				psgmrf_pkg::CFG_WIDE:    wide_q   <= cfg.data[0];
				psgmrf_pkg::CFG_SIGNED:  sgn_q    <= cfg.data[0];
				psgmrf_pkg::CFG_BIG_END: be_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign sample_in.ready = (state_q == ST_IDLE);

	// sequencer, datapath state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			dac_q       <= '0;
			cyc_q       <= '0;
			fs_q        <= '0;
			w_q         <= '0;
			short_q     <= 1'b0;
			lv_q        <= '0;
			rv_q        <= '0;
			acc_l_q     <= '0;
			acc_r_q     <= '0;
			phase_q     <= '0;
			n_q         <= '0;
			k_q         <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			frame_q     <= '0;
			count_q     <= '0;
			last_q      <= 1'b0;
			dropped_q   <= 1'b0;
		end else begin
			if (out_valid_q && sample_out.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_in.valid) begin
						a_q     <= sample_in.level_a;
						b_q     <= sample_in.level_b;
						c_q     <= sample_in.level_c;
						dac_q   <= sample_in.dac_level;
						cyc_q   <= sample_in.cycle_count;
						state_q <= ST_FS;
					end
				end
				ST_FS: begin
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					fs_q    <= prod[25:0];
					state_q <= ST_MIXW;
				end
				ST_MIXW: begin
					unique case (mode_q)
						psgmrf_pkg::MODE_STEREO: begin
							lv_q    <= dac_mix(l_sat, dac_en_q, dac_q);
							rv_q    <= dac_mix(r_sat, dac_en_q, dac_q);
							state_q <= ST_ACCL;
						end
						psgmrf_pkg::MODE_MONO: begin
							lv_q    <= dac_mix(avg, dac_en_q, dac_q);
							rv_q    <= dac_mix(avg, dac_en_q, dac_q);
							state_q <= ST_ACCL;
						end
						psgmrf_pkg::MODE_SPEAKER: begin
							state_q <= ST_SPK1;
						end
						default: begin
							lv_q    <= dac_mix(16'h0000, dac_en_q, dac_q);
							rv_q    <= dac_mix(16'h0000, dac_en_q, dac_q);
							state_q <= ST_ACCL;
						end
					endcase
				end
				ST_SPK1: begin
					state_q <= ST_SPK2;
				end
				ST_SPK2: begin
					lv_q    <= dac_mix(spk_v, dac_en_q, dac_q);
					rv_q    <= dac_mix(spk_v, dac_en_q, dac_q);
					state_q <= ST_ACCL;
				end
				ST_ACCL: begin
					w_q     <= w_now;
					short_q <= fs_short;
					state_q <= ST_ACCR;
				end
				ST_ACCR: begin
					acc_l_q <= acc_l_q + prod[31:16];
					n_q     <= CntW'((total > MaxTotal) ? MaxTotal : total);
					drop_q  <= total > MaxTotal;
					state_q <= ST_ACCW;
				end
				ST_ACCW: begin
					acc_r_q <= acc_r_q + prod[31:16];
					k_q     <= '0;
					if (short_q) begin
						phase_q <= phase_q + fs_q[15:0];
						state_q <= ST_IDLE;
					end else begin
						phase_q <= t_val[15:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						frame_q     <= fmt.bytes;
						count_q     <= fmt.count;
						last_q      <= is_last;
						dropped_q   <= drop_q;
						k_q         <= k_q + CntW'(1);
						if (is_last) begin
							state_q <= ST_POSTL;
						end
					end
				end
				ST_POSTL: begin
					state_q <= ST_POSTR;
				end
				ST_POSTR: begin
					acc_l_q <= prod[31:16];
					state_q <= ST_POSTW;
				end
				ST_POSTW: begin
					acc_r_q <= prod[31:16];
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample_out.valid       = out_valid_q;
	assign sample_out.frame_bytes = frame_q;
	assign sample_out.byte_count  = count_q;
	assign sample_out.last        = last_q;
	assign sample_out.dropped     = dropped_q;

	// checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sample_in.valid && sample_in.ready |=> state_q == ST_FS)
		else $error("accepted transaction did not start the sequencer");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> k_q < n_q && n_q != '0)
		else $error("sample index out of range");

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		sample_out.valid |-> sample_out.byte_count == 3'd1 ||
			sample_out.byte_count == 3'd2 || sample_out.byte_count == 3'd4)
		else $error("illegal byte count");

endmodule

`default_nettype wire

[hdl/psgmrf_mul.sv]
// psgmrf_mul: shared unsigned multiplier with registered product
// depends on psgmrf_pkg
`default_nettype none

module psgmrf_mul (
	input  wire logic                            clk,
	input  wire logic [psgmrf_pkg::MUL_W-1:0]    x,
	input  wire logic [psgmrf_pkg::MUL_W-1:0]    y,
	output logic      [psgmrf_pkg::PROD_W-1:0]   prod
);

	logic [psgmrf_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= psgmrf_pkg::PROD_W'(x) * psgmrf_pkg::PROD_W'(y);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

[tb/tb_psg_mix_resample_format_top.sv]
`timescale 1ns / 1ps
// testbench for psg_mix_resample_format_top: directed table then random phases,
// every result checked against a table entry or a local mixer/resampler/formatter predictor
// depends on psgmrf_pkg, psgmrf_ifs and the block itself

module tb_psg_mix_resample_format_top;

	localparam int unsigned SAMPLE_CAP      = 64;
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned SETTLE_CYCLES   = 24;
	localparam int unsigned TAIL_CYCLES     = 40;
	localparam int unsigned HOLD_CYCLES     = 400;
	localparam int unsigned PHASES          = 8;
	localparam int unsigned ITEMS_PER_PHASE = 18;

	typedef struct packed {
		logic [15:0] level_a;
		logic [15:0] level_b;
		logic [15:0] level_c;
		logic [7:0]  dac_level;
		logic [9:0]  cycle_count;
	} item_t;

	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  count;
		logic        last;
		logic        dropped;
	} frame_t;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  index;
		logic [15:0] value;
		item_t       it;
		logic        typed;
		frame_t      want;
	} row_t;

	localparam item_t  NO_ITEM  = '0;
	localparam frame_t NO_FRAME = '0;

	localparam int PLAN_ROWS = 32;
	localparam row_t PLAN [PLAN_ROWS] = '{
		'{ROW_ITEM,  '0, '0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 10'd1023}, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_STEP, 16'h8000, NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 10'd2}, 1'b1,
			'{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0}},
		'{ROW_ITEM,  '0, '0, '{16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd2}, 1'b1,
			'{32'h0000_0000, 3'd4, 1'b1, 1'b0}},
		'{ROW_WRITE, psgmrf_pkg::CFG_MODE, 16'(psgmrf_pkg::MODE_STEREO),
			NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'hFFFF, 16'h0000, 16'h0000, 8'h00, 10'd2}, 1'b1,
			'{32'h0000_FFFF, 3'd4, 1'b1, 1'b0}},
		'{ROW_ITEM,  '0, '0, '{16'h0000, 16'hFFFF, 16'hFFFF, 8'h00, 10'd3}, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_SIGNED, 16'h0001, NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd1}, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd2}, 1'b1,
			'{32'h8000_8000, 3'd4, 1'b1, 1'b0}},
		'{ROW_WRITE, psgmrf_pkg::CFG_BIG_END, 16'h0001, NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'h1234, 16'h0000, 16'hABCD, 8'h00, 10'd5}, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_WIDE, 16'h0000, NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'h8000, 16'h7FFF, 16'h0001, 8'h00, 10'd7}, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_STEREO, 16'h0000, NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'hFFFF, 16'hFFFF, 16'h0000, 8'h00, 10'd4}, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_WIDE, 16'h0001, NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'h00FF, 16'hFF00, 16'h5555, 8'h00, 10'd6}, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_MODE, 16'(psgmrf_pkg::MODE_SPEAKER),
			NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_SPEAKER, 16'h0000, NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 10'd2}, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_SPEAKER, 16'h00FF, NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 10'd9}, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_DAC_EN, 16'h0001, NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'h0000, 16'h0000, 16'h0000, 8'hFF, 10'd3}, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_MODE, 16'(psgmrf_pkg::MODE_SILENT),
			NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h80, 10'd1}, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_STEP, 16'hFFFF, NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'hAAAA, 16'h5555, 16'hFFFF, 8'h00, 10'd1023}, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'h5555, 16'hAAAA, 16'h0000, 8'h7F, 10'd0}, 1'b0, NO_FRAME},
		'{ROW_WRITE, psgmrf_pkg::CFG_STEP, 16'h0000, NO_ITEM, 1'b0, NO_FRAME},
		'{ROW_ITEM,  '0, '0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 10'd1023}, 1'b0, NO_FRAME}
	};

	logic clk = 1'b0;
	logic arst_n;

	psgmrf_in_if  in_ch ();
	psgmrf_out_if out_ch ();
	psgmrf_cfg_if cfg_ch ();

	psg_mix_resample_format_top #(
		.MAX_SAMPLES_PER_ITEM(SAMPLE_CAP)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (in_ch),
		.sample_out (out_ch),
		.cfg        (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// register copy
	logic [15:0] cfg_step;
	logic [1:0]  cfg_mode;
	logic [7:0]  cfg_spk;
	logic        cfg_dac, cfg_stereo, cfg_wide, cfg_sgn, cfg_be;

	// resampler state copy
	logic [15:0] phase_frac, sum_l, sum_r;

	frame_t frames_due [$];
	frame_t fresh_frames [$];
	frame_t head;

	bit          calm, squeeze, squeezed;
	int unsigned faults, items_sent, frames_seen, capped_items, reg_writes, cycle_no;

	function automatic logic [15:0] order16(input logic [15:0] v);
		return cfg_be ? {v[7:0], v[15:8]} : v;
	endfunction

	function automatic frame_t shape_frame(input logic [15:0] l, input logic [15:0] r);
		frame_t      f;
		logic [16:0] s;
		logic [15:0] w0, w1;
		logic [7:0]  b0, b1;
		f = '0;
		if (cfg_stereo) begin
			if (!cfg_wide) begin
				b0 = l[15:8];
				b1 = r[15:8];
				if (cfg_sgn) begin
					b0 = b0 + 8'h80;
					b1 = b1 + 8'h80;
				end
				f.bytes = {16'h0000, b1, b0};
				f.count = 3'd2;
			end else begin
				w0 = l;
				w1 = r;
				if (cfg_sgn) begin
					w0 = w0 + 16'h8000;
					w1 = w1 + 16'h8000;
				end
				f.bytes = {order16(w1), order16(w0)};
				f.count = 3'd4;
			end
		end else begin
			s  = {1'b0, l} + {1'b0, r};
			w0 = s[16:1];
			if (!cfg_wide) begin
				b0 = w0[15:8];
				if (cfg_sgn)
					b0 = b0 + 8'h80;
				f.bytes = {24'h000000, b0};
				f.count = 3'd1;
			end else begin
				if (cfg_sgn)
					w0 = w0 + 16'h8000;
				f.bytes = {16'h0000, order16(w0)};
				f.count = 3'd2;
			end
		end
		return f;
	endfunction

	// (level * span) >> 16, low 16 bits
	function automatic logic [15:0] span_part(input int unsigned lvl, input int unsigned span);
		logic [63:0] p;
		p = 64'(lvl) * 64'(span);
		return p[31:16];
	endfunction

	task automatic predict_item(input item_t it);
		int unsigned lv, rv, mid, avg, d, fs, rem, t, total, n;
		frame_t      f;
		fresh_frames.delete();
		case (cfg_mode) inside
			psgmrf_pkg::MODE_STEREO: begin
				mid = (32'(it.level_b) * 32'd10) / 32'd22;
				lv  = 32'(it.level_a) + mid;
				rv  = 32'(it.level_c) + mid;
				if (lv > 32'd65535) lv = 32'd65535;
				if (rv > 32'd65535) rv = 32'd65535;
			end
			psgmrf_pkg::MODE_MONO, psgmrf_pkg::MODE_SPEAKER: begin
				avg = (32'(it.level_a) + 32'(it.level_b) + 32'(it.level_c)) / 32'd3;
				if (cfg_mode == psgmrf_pkg::MODE_SPEAKER)
					avg = (avg * 32'(cfg_spk)) / psgmrf_pkg::SPEAKER_LEVEL_MAX;
				if (avg > 32'd65535) avg = 32'd65535;
				lv = avg;
				rv = avg;
			end
			default: begin
				lv = 0;
				rv = 0;
			end
		endcase
		if (cfg_dac) begin
			d  = (32'(it.dac_level) * 32'd257) / 32'd2;
			lv = lv / 32'd2 + d;
			rv = rv / 32'd2 + d;
		end
		fs  = 32'(cfg_step) * 32'(it.cycle_count);
		rem = 32'h10000 - 32'(phase_frac);
		if (fs < rem) begin
			sum_l      = sum_l + span_part(lv, fs);
			sum_r      = sum_r + span_part(rv, fs);
			phase_frac = phase_frac + fs[15:0];
		end else begin
			sum_l = sum_l + span_part(lv, rem);
			sum_r = sum_r + span_part(rv, rem);
			t     = fs - rem;
			total = 32'd1 + (t >> 16);
			n     = (total > SAMPLE_CAP) ? SAMPLE_CAP : total;
			for (int unsigned k = 0; k < n; k++) begin
				f = (k == 0) ? shape_frame(sum_l, sum_r) : shape_frame(lv[15:0], rv[15:0]);
				f.last    = (k + 1 == n);
				f.dropped = (total > n);
				fresh_frames.push_back(f);
			end
			if (total > n)
				capped_items++;
			phase_frac = t[15:0];
			sum_l      = span_part(lv, 32'(phase_frac));
			sum_r      = span_part(rv, 32'(phase_frac));
		end
	endtask

	// called at a falling edge; leaves at the falling edge after the transaction
	task automatic send_item(input item_t it, input logic typed, input frame_t want);
		while (!calm && $urandom_range(0, 99) < 15) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.level_a     <= it.level_a;
		in_ch.level_b     <= it.level_b;
		in_ch.level_c     <= it.level_c;
		in_ch.dac_level   <= it.dac_level;
		in_ch.cycle_count <= it.cycle_count;
		do @(posedge clk); while (!in_ch.ready);
		predict_item(it);
		if (typed)
			frames_due.push_back(want);
		else
			foreach (fresh_frames[i])
				frames_due.push_back(fresh_frames[i]);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		logic [15:0] keep;
		case (idx)
			psgmrf_pkg::CFG_STEP:    keep = 16'hFFFF;
			psgmrf_pkg::CFG_MODE:    keep = 16'h0003;
			psgmrf_pkg::CFG_SPEAKER: keep = 16'h00FF;
			default:                 keep = 16'h0001;
		endcase
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= (value & keep) | (($urandom_range(0, 1) ? 16'($urandom) : 16'h0000) & ~keep);
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			psgmrf_pkg::CFG_STEP:    cfg_step   = value;
			psgmrf_pkg::CFG_MODE:    cfg_mode   = value[1:0];
			psgmrf_pkg::CFG_SPEAKER: cfg_spk    = value[7:0];
			psgmrf_pkg::CFG_DAC_EN:  cfg_dac    = value[0];
			psgmrf_pkg::CFG_STEREO:  cfg_stereo = value[0];
			psgmrf_pkg::CFG_WIDE:    cfg_wide   = value[0];
			psgmrf_pkg::CFG_SIGNED:  cfg_sgn    = value[0];
			psgmrf_pkg::CFG_BIG_END: cfg_be     = value[0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (frames_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_level();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return 16'($urandom);
	endfunction

	function automatic item_t random_item();
		item_t       it;
		int unsigned pick;
		it.level_a   = pick_level();
		it.level_b   = pick_level();
		it.level_c   = pick_level();
		it.dac_level = 8'($urandom);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			it.cycle_count = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
		else if (pick <= 2)
			it.cycle_count = 10'($urandom);
		else
			it.cycle_count = 10'($urandom_range(0, 15));
		return it;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			frames_seen++;
			if (frames_due.size() == 0) begin
				$error("unexpected transaction: frame_bytes %h byte_count %0d",
					out_ch.frame_bytes, out_ch.byte_count);
				faults++;
			end else begin
				head = frames_due.pop_front();
				if (out_ch.frame_bytes !== head.bytes) begin
					$error("frame_bytes: expected %h, got %h", head.bytes, out_ch.frame_bytes);
					faults++;
				end
				if (out_ch.byte_count !== head.count) begin
					$error("byte_count: expected %0d, got %0d", head.count, out_ch.byte_count);
					faults++;
				end
				if (out_ch.last !== head.last) begin
					$error("last: expected %b, got %b", head.last, out_ch.last);
					faults++;
				end
				if (out_ch.dropped !== head.dropped) begin
					$error("dropped: expected %b, got %b", head.dropped, out_ch.dropped);
					faults++;
				end
			end
		end
	end

	// receiver with random idling and one long hold-off
	initial begin
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (squeeze && !squeezed) begin
				squeezed = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
			end
		end
	end

	initial begin
		while (cycle_no < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_no++;
		end
		$display("psg_mix_resample_format_top: mismatch");
		$finish;
	end

	initial begin
		logic [15:0] v_step;
		logic [1:0]  v_mode;
		logic [7:0]  v_spk;
		logic        v_dac, v_st, v_wide, v_sgn, v_be;
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.level_a     = '0;
		in_ch.level_b     = '0;
		in_ch.level_c     = '0;
		in_ch.dac_level   = '0;
		in_ch.cycle_count = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = psgmrf_pkg::CFG_STEP;
		cfg_ch.data       = '0;
		cfg_step   = 16'h0000;
		cfg_mode   = psgmrf_pkg::MODE_MONO;
		cfg_spk    = 8'hFF;
		cfg_dac    = 1'b0;
		cfg_stereo = 1'b1;
		cfg_wide   = 1'b1;
		cfg_sgn    = 1'b0;
		cfg_be     = 1'b0;
		phase_frac = '0;
		sum_l      = '0;
		sum_r      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].kind == ROW_WRITE) begin
				settle();
				write_reg(PLAN[i].index, PLAN[i].value);
			end else begin
				send_item(PLAN[i].it, PLAN[i].typed, PLAN[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			calm    = (ph == 3);
			squeeze = (ph == 2);
			case (ph)
				0: begin
					v_step = 16'h0100;
					v_mode = psgmrf_pkg::MODE_MONO;
					v_spk  = 8'h00;
					{v_dac, v_st, v_wide, v_sgn, v_be} = '0;
				end
				1: begin
					v_step = 16'hFFFF;
					v_mode = psgmrf_pkg::MODE_SILENT;
					v_spk  = 8'hFF;
					{v_dac, v_st, v_wide, v_sgn, v_be} = '1;
				end
				default: begin
					case ($urandom_range(0, 3))
						1:       v_step = 16'($urandom_range(1, 16'h0800));
						2:       v_step = 16'($urandom_range(16'h0800, 16'h4000));
						default: v_step = 16'($urandom);
					endcase
					if (ph == 2)
						v_step = 16'($urandom_range(16'h1000, 16'h6000));
					v_mode = 2'($urandom);
					v_spk  = 8'($urandom);
					{v_dac, v_st, v_wide, v_sgn, v_be} = 5'($urandom);
				end
			endcase
			write_reg(psgmrf_pkg::CFG_STEP, v_step);
			write_reg(psgmrf_pkg::CFG_MODE, 16'(v_mode));
			write_reg(psgmrf_pkg::CFG_SPEAKER, 16'(v_spk));
			write_reg(psgmrf_pkg::CFG_DAC_EN, 16'(v_dac));
			write_reg(psgmrf_pkg::CFG_STEREO, 16'(v_st));
			write_reg(psgmrf_pkg::CFG_WIDE, 16'(v_wide));
			write_reg(psgmrf_pkg::CFG_SIGNED, 16'(v_sgn));
			write_reg(psgmrf_pkg::CFG_BIG_END, 16'(v_be));
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_item(random_item(), 1'b0, NO_FRAME);
		end

		in_ch.valid <= 1'b0;
		calm = 1'b0;
		while (frames_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d input items and %0d output samples, %0d register writes",
			items_sent, frames_seen, reg_writes);
		$display("%0d items ran past the sample cap; output held off %0d cycles under load",
			capped_items, squeezed ? HOLD_CYCLES : 0);
		if (faults == 0 && frames_due.size() == 0)
			$display("psg_mix_resample_format_top: match");
		else
			$display("psg_mix_resample_format_top: mismatch");
		$finish;
	end

endmodule
